### rtl/core/smw_pkg.sv
`default_nettype none
// ============================================================================
// smw_pkg
// Shared types and widths for the column melt wipe core and its divider.
// ============================================================================
package smw_pkg;

   // Product of a column index (plus one) and a screen dimension
   localparam int PROD_W      = 21;
   // Scaled reciprocal of a column count or melt line count. With a shift of
   // 31 the truncated product equals the quotient for every dividend below
   // 2^PROD_W and every divisor up to 1024.
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 31;

   // Request into the shared divider
   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  dividend;
      logic [RECIP_W-1:0] recip;
   } div_req_type;

endpackage
`default_nettype wire

### rtl/core/smw_div.sv
`default_nettype none
// ============================================================================
// smw_div
// Constant divider: multiply by a scaled reciprocal, quotient in the next cycle.
// ============================================================================
module smw_div
   import smw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_req_type       div_req,
   output logic                   done,
   output logic [PROD_W-1:0]      quotient
);

   localparam int SCALED_W = PROD_W + RECIP_W;

   logic                done_ff;
   logic [PROD_W-1:0]   quo_ff;
   logic [SCALED_W-1:0] scaled;

   // Scale the dividend by the reciprocal; the top bits are the quotient
   assign scaled = SCALED_W'(div_req.dividend) * SCALED_W'(div_req.recip);

   // Flag the quotient in the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= div_req.start;
      end
   end

   // Capture the quotient on start
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= scaled[RECIP_SHIFT +: PROD_W];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### rtl/core/screen_melt_column_wipe.sv
`default_nettype none
// ============================================================================
// screen_melt_column_wipe
// Column melt offsets with seed, tick and strip query commands.
// ============================================================================
// Usage:
//   Command channel: drive start with req_kind/req_column/req_random_value;
//   the command transfers on a clock edge with start high and busy low.
//   Every command returns exactly one result, shown on the rsp_ ports for
//   one cycle with rsp_valid high. The receiver cannot stall; the result
//   register frees the sequencer, so a new command may transfer in the
//   same cycle that a result is shown.
//   Seed: read previous column, write this one, then the result.
//   Tick: the offset memory is swept one entry
//   per cycle, read and write overlapped on its one read and one write port.
//   Query: the shared multiplier and a reciprocal-multiply
//   constant divider produce left x, right x and top y in turn, each
//   as a multiply step followed by a divide step.
//   Out of range seeds and queries, and the unused kind, answer in the cycle after they transfer.
//   Configuration: csr_ valid/ready write channel, always ready; write only
//   while the block is idle. Reset (synchronous) restores width 320 and
//   height 200 and idles the sequencer; offsets hold until seeded.
// ============================================================================
module screen_melt_column_wipe
   import smw_pkg::*;
#(
   parameter int NUM_COLUMNS = 160,
   parameter int MELT_LINES  = 200
)(
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_column,
   input  wire logic [7:0]  req_random_value,
   // result channel
   output logic             rsp_valid,
   output logic             rsp_all_done,
   output logic [11:0]      rsp_strip_left,
   output logic [11:0]      rsp_strip_right,
   output logic [11:0]      rsp_strip_top,
   output logic             rsp_strip_drawn,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_data
);

   localparam int ADDR_W = $clog2(NUM_COLUMNS);
   localparam logic [8:0] MELT_CAP = 9'(MELT_LINES);
   localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(NUM_COLUMNS - 1);

   // Rounded-up reciprocals of the two constant divisors
   localparam logic [RECIP_W-1:0] RECIP_COLS =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(NUM_COLUMNS) - 64'd1) / 64'(NUM_COLUMNS));
   localparam logic [RECIP_W-1:0] RECIP_LINES =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MELT_LINES) - 64'd1) / 64'(MELT_LINES));

   localparam logic [1:0] KIND_SEED  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEED_RD,
      S_SEED_WR,
      S_TICK_RUN,
      S_TICK_DRAIN,
      S_Q_MUL_L,
      S_Q_DIV_L,
      S_Q_MUL_R,
      S_Q_DIV_R,
      S_Q_MUL_T,
      S_Q_DIV_T
   } state_type;

   // Seed rule: first column from the low nibble, later ones walk and clamp
   function automatic logic [8:0] seed_value(logic first, logic [8:0] prev,
                                             logic [7:0] r);
      logic [3:0]        s;
      logic [1:0]        m;
      logic signed [9:0] sum;
      s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
      case (s) inside
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       m = 2'd1;
         default:                       m = 2'd2;
      endcase
      sum = $signed({prev[8], prev}) + $signed({8'b0, m}) - 10'sd1;
      if (first) begin
         seed_value = 9'd0 - {5'd0, r[3:0]};
      end else if (sum < -10'sd15) begin
         seed_value = 9'h1F1;
      end else if (sum > 10'sd0) begin
         seed_value = 9'd0;
      end else begin
         seed_value = sum[8:0];
      end
   endfunction

   // Tick rule: returns {moved, next offset}
   function automatic logic [9:0] tick_value(logic [8:0] v);
      logic [9:0] dy;
      logic [9:0] sum;
      dy  = (v < 9'd16) ? ({1'b0, v} + 10'd1) : 10'd8;
      sum = {1'b0, v} + dy;
      if (v[8]) begin
         tick_value = {1'b1, v + 9'd1};
      end else if (v < MELT_CAP) begin
         tick_value = (sum > {1'b0, MELT_CAP}) ? {1'b1, MELT_CAP} : {1'b1, sum[8:0]};
      end else begin
         tick_value = {1'b0, v};
      end
   endfunction

   state_type          state_ff;
   logic [1:0]         kind_ff;
   logic [7:0]         col_ff;
   logic [7:0]         rnd_ff;
   logic [11:0]        scr_w_ff;
   logic [11:0]        scr_h_ff;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0]  tick_addr_ff;
   logic               tick_pend_ff;
   logic               moved_ff;
   logic               div_start_ff;
   logic [RECIP_W-1:0] div_recip_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff;
   logic               rsp_all_done_ff;
   logic [11:0]        rsp_left_ff;
   logic [11:0]        rsp_right_ff;
   logic [11:0]        rsp_top_ff;
   logic               rsp_drawn_ff;

   logic [8:0]         mem [NUM_COLUMNS];
   logic [8:0]         rd_data_ff;
   logic               mem_rd;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic               mem_wr;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [8:0]         mem_wr_data;

   logic               accept;
   logic               col_ok;
   logic [9:0]         tick_next;
   logic [11:0]        mul_a;
   logic [8:0]         mul_b;
   logic [PROD_W-1:0]  mul_p;
   div_req_type        div_req;
   logic               div_done;
   logic [PROD_W-1:0]  div_quot;
   logic [11:0]        quot12;

   assign accept    = start && !busy;
   assign col_ok    = int'(req_column) < NUM_COLUMNS;
   assign tick_next = tick_value(rd_data_ff);
   assign quot12    = div_quot[11:0];

   // Steer the offset memory ports from the sequencer state
   always_comb begin
      mem_rd      = 1'b0;
      mem_rd_addr = ADDR_W'(col_ff);
      mem_wr      = 1'b0;
      mem_wr_addr = tick_addr_ff;
      mem_wr_data = tick_next[8:0];
      case (state_ff)
         S_SEED_RD: begin
            mem_rd      = (col_ff != 8'd0);
            mem_rd_addr = ADDR_W'(col_ff - 8'd1);
         end
         S_SEED_WR: begin
            mem_wr      = 1'b1;
            mem_wr_addr = ADDR_W'(col_ff);
            mem_wr_data = seed_value(col_ff == 8'd0, rd_data_ff, rnd_ff);
         end
         S_TICK_RUN: begin
            mem_rd      = 1'b1;
            mem_rd_addr = cnt_ff;
            mem_wr      = tick_pend_ff;
         end
         S_TICK_DRAIN: begin
            mem_wr = tick_pend_ff;
         end
         S_Q_MUL_L: begin
            mem_rd = 1'b1;
         end
         default: begin
            mem_rd = 1'b0;
         end
      endcase
   end

   // Offset memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = scr_w_ff;
      mul_b = {1'b0, col_ff};
      case (state_ff)
         S_Q_MUL_R: mul_b = {1'b0, col_ff} + 9'd1;
         S_Q_MUL_T: begin
            mul_a = scr_h_ff;
            mul_b = rd_data_ff[8] ? 9'd0 : rd_data_ff;
         end
         default:   mul_b = {1'b0, col_ff};
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = prod_ff;
   assign div_req.recip    = div_recip_ff;

   smw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= 12'd320;
         scr_h_ff <= 12'd200;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  scr_w_ff <= csr_data;
            REG_SCREEN_HEIGHT: scr_h_ff <= csr_data;
            default:           scr_w_ff <= scr_w_ff;
         endcase
      end
   end

   // Multiplier result register
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_pend_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff         <= req_kind;
                  col_ff          <= req_column;
                  rnd_ff          <= req_random_value;
                  cnt_ff          <= '0;
                  moved_ff        <= 1'b0;
                  tick_pend_ff    <= 1'b0;
                  rsp_all_done_ff <= 1'b0;
                  rsp_left_ff     <= '0;
                  rsp_right_ff    <= '0;
                  rsp_top_ff      <= '0;
                  rsp_drawn_ff    <= 1'b0;
                  case (req_kind)
                     KIND_SEED: begin
                        if (col_ok) state_ff <= S_SEED_RD;
                        else        rsp_valid_ff <= 1'b1;
                     end
                     KIND_TICK: state_ff <= S_TICK_RUN;
                     KIND_QUERY: begin
                        if (col_ok) state_ff <= S_Q_MUL_L;
                        else        rsp_valid_ff <= 1'b1;
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            S_SEED_RD: state_ff <= S_SEED_WR;
            S_SEED_WR: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_TICK_RUN: begin
               tick_pend_ff <= 1'b1;
               tick_addr_ff <= cnt_ff;
               if (tick_pend_ff) moved_ff <= moved_ff | tick_next[9];
               if (cnt_ff == LAST_COL) state_ff <= S_TICK_DRAIN;
               else                    cnt_ff   <= cnt_ff + 1'b1;
            end
            S_TICK_DRAIN: begin
               tick_pend_ff    <= 1'b0;
               rsp_all_done_ff <= ~(moved_ff | tick_next[9]);
               rsp_valid_ff    <= 1'b1;
               state_ff        <= S_IDLE;
            end
            S_Q_MUL_L: begin
               div_start_ff <= 1'b1;
               div_recip_ff <= RECIP_COLS;
               state_ff     <= S_Q_DIV_L;
            end
            S_Q_DIV_L: begin
               if (div_done) begin
                  rsp_left_ff <= quot12;
                  state_ff    <= S_Q_MUL_R;
               end
            end
            S_Q_MUL_R: begin
               div_start_ff <= 1'b1;
               div_recip_ff <= RECIP_COLS;
               state_ff     <= S_Q_DIV_R;
            end
            S_Q_DIV_R: begin
               if (div_done) begin
                  rsp_right_ff <= quot12;
                  state_ff     <= S_Q_MUL_T;
               end
            end
            S_Q_MUL_T: begin
               div_start_ff <= 1'b1;
               div_recip_ff <= RECIP_LINES;
               state_ff     <= S_Q_DIV_T;
            end
            S_Q_DIV_T: begin
               if (div_done) begin
                  rsp_top_ff   <= quot12;
                  rsp_drawn_ff <= (scr_h_ff > quot12);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_all_done    = rsp_all_done_ff;
   assign rsp_strip_left  = rsp_left_ff;
   assign rsp_strip_right = rsp_right_ff;
   assign rsp_strip_top   = rsp_top_ff;
   assign rsp_strip_drawn = rsp_drawn_ff;

`ifndef SYNTHESIS
   // A result follows either a busy cycle or the transfer of a command
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(accept))
      else $error("result without a command in progress");

   // An accepted command either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid)
      else $error("command transfer dropped");

   // Divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_Q_DIV_L) || (state_ff == S_Q_DIV_R)
                   || (state_ff == S_Q_DIV_T))
      else $error("divider done outside a divide step");

   // Tick result flags done only on a tick
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_done |-> kind_ff == KIND_TICK)
      else $error("done flag on a non-tick result");
`endif

endmodule
`default_nettype wire
